// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the LZSS ring decompressor.
// Needs nothing else; each macro expands to one concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== hdl/lzss_pkg.sv =====
// Package for the LZSS ring decompressor: sizes, parse phase codes and the
// command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package lzss_pkg;

  localparam int WINDOW_SIZE = 4096;
  localparam int RING_AW     = $clog2(WINDOW_SIZE);
  localparam int CNT_W       = 24;
  localparam int REM_W       = 5;

  localparam logic [RING_AW-1:0] RING_START = RING_AW'(12'hFEE);
  localparam logic [REM_W-1:0]   LEN_BIAS   = REM_W'(3);

  localparam logic [1:0] PH_FLAG = 2'd0;
  localparam logic [1:0] PH_ITEM = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;

  typedef struct packed {
    logic latch_in;
    logic load_flags;
    logic store_low;
    logic start_copy;
    logic rd_en;
    logic emit_lit;
    logic emit_copy;
    logic emit_stat;
  } cmd_t;

  typedef struct packed {
    logic       active;
    logic [1:0] phase;
    logic       flag_bit;
    logic       last;
    logic       copy_end;
    logic       out_free;
  } stat_t;

endpackage

// ===== hdl/lzss_ctrl.sv =====
// Controller state machine of the LZSS ring decompressor.
// Uses lzss_pkg for the command and status structs; drives lzss_dpath.
`timescale 1ns / 1ps

module lzss_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lzss_pkg::stat_t stat,
  output lzss_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_LIT  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;
  localparam logic [2:0] S_STAT = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic [2:0] after_item;

  assign in_ready   = (state_r == S_IDLE);
  assign after_item = stat.last ? S_STAT : S_IDLE;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.latch_in = in_valid;
        if (in_valid) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (!stat.active) begin
          state_nxt = after_item;
        end else if (stat.phase == lzss_pkg::PH_FLAG) begin
          cmd.load_flags = 1'b1;
          state_nxt      = after_item;
        end else if (stat.phase == lzss_pkg::PH_ITEM) begin
          if (stat.flag_bit) begin
            state_nxt = S_LIT;
          end else begin
            cmd.store_low = 1'b1;
            state_nxt     = after_item;
          end
        end else begin
          cmd.start_copy = 1'b1;
          state_nxt      = S_RD;
        end
      end
      S_LIT: begin
        cmd.emit_lit = stat.out_free;
        if (stat.out_free) begin
          state_nxt = after_item;
        end
      end
      S_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        cmd.emit_copy = stat.out_free;
        if (stat.out_free) begin
          state_nxt = stat.copy_end ? after_item : S_RD;
        end
      end
      S_STAT: begin
        cmd.emit_stat = stat.out_free;
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/lzss_dpath.sv =====
// Datapath of the LZSS ring decompressor: window ring memory, parse state,
// byte counters, length register and the output register. Uses lzss_pkg.
`timescale 1ns / 1ps

module lzss_dpath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  input  logic [23:0]               cfg_out_length,
  input  logic [7:0]                in_byte,
  input  logic                      in_last_in,
  input  lzss_pkg::cmd_t            cmd,
  output lzss_pkg::stat_t           stat,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [7:0]                out_byte,
  output logic                      out_is_status,
  output logic                      out_status_code,
  output logic                      out_last_of_run
);

  localparam int AW = lzss_pkg::RING_AW;
  localparam int CW = lzss_pkg::CNT_W;
  localparam int RW = lzss_pkg::REM_W;

  logic [7:0]    ring [lzss_pkg::WINDOW_SIZE];

  logic [7:0]    byte_r;
  logic          last_r;
  logic [7:0]    flags_r;
  logic [2:0]    idx_r;
  logic [1:0]    phase_r;
  logic [7:0]    low_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] len_r;
  logic [AW-1:0] wpos_r;
  logic [AW-1:0] ptr_r;
  logic [RW-1:0] rem_r;
  logic [7:0]    rd_r;
  logic          rd_ok_r;

  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic          out_is_status_r;
  logic          out_status_code_r;
  logic          out_last_of_run_r;

  logic          active;
  logic          copy_end;
  logic          emit_data;
  logic          step_bit;
  logic [7:0]    copy_byte;
  logic [7:0]    data_byte;
  logic [AW-1:0] start_ofs;
  logic          written;

  assign active    = (count_r < len_r);
  assign copy_end  = (rem_r == RW'(1)) || (({1'b0, count_r} + (CW+1)'(1)) >= {1'b0, len_r});
  assign emit_data = cmd.emit_lit | cmd.emit_copy;
  assign step_bit  = cmd.emit_lit | (cmd.emit_copy & copy_end);
  assign copy_byte = rd_ok_r ? rd_r : 8'h00;
  assign data_byte = cmd.emit_lit ? byte_r : copy_byte;

  // Writes run forward from the start position, so an entry holds stream
  // data exactly when its distance from the start is below the byte count.
  assign start_ofs = ptr_r - lzss_pkg::RING_START;
  assign written   = (count_r[CW-1:AW] != '0) || ({{(CW-AW){1'b0}}, start_ofs} < count_r);

  assign stat.active   = active;
  assign stat.phase    = phase_r;
  assign stat.flag_bit = flags_r[idx_r];
  assign stat.last     = last_r;
  assign stat.copy_end = copy_end;
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_is_status   = out_is_status_r;
  assign out_status_code = out_status_code_r;
  assign out_last_of_run = out_last_of_run_r;

  always_ff @(posedge clk) begin
    if (emit_data) begin
      ring[wpos_r] <= data_byte;
    end
    if (cmd.rd_en) begin
      rd_r    <= ring[ptr_r];
      rd_ok_r <= written;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      flags_r     <= '0;
      idx_r       <= '0;
      phase_r     <= lzss_pkg::PH_FLAG;
      low_r       <= '0;
      count_r     <= '0;
      wpos_r      <= lzss_pkg::RING_START;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        len_r <= cfg_out_length;
      end
      if (cmd.load_flags) begin
        flags_r <= byte_r;
        idx_r   <= '0;
        phase_r <= lzss_pkg::PH_ITEM;
      end
      if (cmd.store_low) begin
        low_r   <= byte_r;
        phase_r <= lzss_pkg::PH_HIGH;
      end
      if (emit_data) begin
        wpos_r  <= wpos_r + AW'(1);
        count_r <= count_r + CW'(1);
      end
      if (step_bit) begin
        if (idx_r == 3'd7) begin
          idx_r   <= '0;
          phase_r <= lzss_pkg::PH_FLAG;
        end else begin
          idx_r   <= idx_r + 3'd1;
          phase_r <= lzss_pkg::PH_ITEM;
        end
      end
      if (cmd.emit_stat) begin
        flags_r <= '0;
        idx_r   <= '0;
        phase_r <= lzss_pkg::PH_FLAG;
        low_r   <= '0;
        count_r <= '0;
        wpos_r  <= lzss_pkg::RING_START;
      end
      if (emit_data || cmd.emit_stat) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      byte_r <= in_byte;
      last_r <= in_last_in;
    end
    if (cmd.start_copy) begin
      ptr_r <= {byte_r[7:4], low_r};
      rem_r <= {1'b0, byte_r[3:0]} + lzss_pkg::LEN_BIAS;
    end
    if (cmd.emit_copy) begin
      ptr_r <= ptr_r + AW'(1);
      rem_r <= rem_r - RW'(1);
    end
    if (emit_data) begin
      out_byte_r        <= data_byte;
      out_is_status_r   <= 1'b0;
      out_status_code_r <= 1'b0;
      // Only the closing byte of a literal or copy ends the run, unless a status follows.
      out_last_of_run_r <= !last_r && (cmd.emit_lit || copy_end);
    end else if (cmd.emit_stat) begin
      out_byte_r        <= 8'h00;
      out_is_status_r   <= 1'b1;
      out_status_code_r <= active;
      out_last_of_run_r <= 1'b1;
    end
  end

endmodule

// ===== hdl/lzss_ring_decompressor.sv =====
// LZSS ring decompressor top level: lzss_ctrl sequences lzss_dpath (lzss_pkg).
// A flag byte or reference low byte passes the idle and decode states, a literal
// adds the literal state, and a back-reference adds a registered ring read and
// then a ring write per copied byte. An end-of-stream status adds a status state;
// a full output register stalls the work. Synchronous active-low reset empties the
// ring by zeroing the fill count, so the block accepts input after reset with no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lzss_ring_decompressor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_out_length,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_is_status,
  output logic        out_status_code,
  output logic        out_last_of_run
);

  lzss_pkg::cmd_t  cmd;
  lzss_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  lzss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lzss_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_out_length  (cfg_out_length),
    .in_byte         (in_byte),
    .in_last_in      (in_last_in),
    .cmd             (cmd),
    .stat            (stat),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_byte        (out_byte),
    .out_is_status   (out_is_status),
    .out_status_code (out_status_code),
    .out_last_of_run (out_last_of_run)
  );

  `ASSERT_ALWAYS(a_one_request, clk, rst_n, (in_valid && in_ready) |=> !in_ready, "input taken while decoding")
  `ASSERT_ALWAYS(a_status_last, clk, rst_n, (out_valid && out_is_status) |-> (out_last_of_run && out_byte == 8'h00), "status result malformed")
  `ASSERT_NEVER(a_data_code, clk, rst_n, out_valid && !out_is_status && out_status_code, "data result carries a status code")
  `ASSERT_NEVER(a_emit_overlap, clk, rst_n, (cmd.emit_lit || cmd.emit_copy || cmd.emit_stat) && !stat.out_free, "result written over a waiting one")

endmodule
